/* hw/rtl/eiec_pkg.sv */
// eiec_pkg: shared constants, bus codes and types for the external
// interrupt edge controller. No dependencies.
`timescale 1ns / 1ps

package eiec_pkg;

  // Line counts and port geometry
  localparam int DEF_NUM_LINES       = 23;
  localparam int GPIO_LINES          = 16;
  localparam int INTERNAL_COUNT      = 7;
  localparam int NUM_PORTS           = 9;
  localparam int LAST_PORT           = 8;
  localparam int LAST_PORT_PIN_LIMIT = 12;
  localparam int PINS_PER_PORT       = 16;
  localparam int CODE_W              = 4;
  localparam int PIN_FIELD_W         = 48;
  localparam int PIN_VEC_W           = 256;  // one slot per {code, pin}
  localparam int DATA_W              = 32;
  localparam int GROUP_W             = 7;

  // Bus actions
  localparam logic [1:0] FUNC_NONE  = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_WRITE = 2'd2;

  // Register addresses
  localparam logic [3:0] REG_IMASK   = 4'd0;
  localparam logic [3:0] REG_EMASK   = 4'd1;
  localparam logic [3:0] REG_RISE    = 4'd2;
  localparam logic [3:0] REG_FALL    = 4'd3;
  localparam logic [3:0] REG_SWTRIG  = 4'd4;
  localparam logic [3:0] REG_PENDING = 4'd5;
  localparam logic [3:0] REG_PSEL0   = 4'd6;
  localparam logic [3:0] REG_PSEL1   = 4'd7;
  localparam logic [3:0] REG_PSEL2   = 4'd8;
  localparam logic [3:0] REG_PSEL3   = 4'd9;

  // One register access carried with a beat
  typedef struct packed {
    logic [1:0]        func;
    logic [3:0]        addr;
    logic [DATA_W-1:0] wdata;
  } bus_req_t;

  // Port-select codes of the sixteen GPIO lines
  typedef logic [GPIO_LINES-1:0][CODE_W-1:0] port_sel_t;

endpackage

/* hw/rtl/eiec_line_mux.sv */
// eiec_line_mux: picks the sampled level of every interrupt line from the
// selected GPIO port pin or the internal sources. Uses eiec_pkg.
`timescale 1ns / 1ps

module eiec_line_mux
  import eiec_pkg::*;
#(
  parameter int NUM_LINES = DEF_NUM_LINES
) (
  input  port_sel_t                port_sel,
  input  logic [PIN_FIELD_W-1:0]   pins_low_ports,
  input  logic [PIN_FIELD_W-1:0]   pins_mid_ports,
  input  logic [PIN_FIELD_W-1:0]   pins_high_ports,
  input  logic [INTERNAL_COUNT-1:0] internal_sources,
  output logic [NUM_LINES-1:0]     levels
);

  // All pins in {port, pin} order, padded so any 4-bit code stays in range
  logic [PIN_VEC_W-1:0] pin_vec;

  assign pin_vec = {(PIN_VEC_W - 3 * PIN_FIELD_W)'(0),
                    pins_high_ports, pins_mid_ports, pins_low_ports};

  for (genvar i = 0; i < NUM_LINES; i++) begin : g_line
    if (i < GPIO_LINES) begin : g_gpio
      logic [CODE_W-1:0] code;
      logic              mapped;
      logic [7:0]        idx;
      assign code   = port_sel[i];
      // codes past the last port, and port 8 upper pins, read low
      assign mapped = (32'(code) < NUM_PORTS) &&
                      !((32'(code) == LAST_PORT) && (i >= LAST_PORT_PIN_LIMIT));
      assign idx    = {code, 4'(i)};
      assign levels[i] = mapped & pin_vec[idx];
    end else if (i - GPIO_LINES < INTERNAL_COUNT) begin : g_int
      assign levels[i] = internal_sources[i - GPIO_LINES];
    end else begin : g_none
      assign levels[i] = 1'b0;
    end
  end

endmodule

/* hw/rtl/eiec_core.sv */
// eiec_core: control registers, edge detection, pending logic and the
// result values of one beat. Uses eiec_pkg.
`timescale 1ns / 1ps

module eiec_core
  import eiec_pkg::*;
#(
  parameter int NUM_LINES = DEF_NUM_LINES
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  bus_req_t             req,
  input  logic [NUM_LINES-1:0] levels,
  output port_sel_t            port_sel,
  output logic [DATA_W-1:0]    rd_next,
  output logic [NUM_LINES-1:0] pending_next,
  output logic [NUM_LINES-1:0] irq_next,
  output logic [GROUP_W-1:0]   grp_next,
  output logic [NUM_LINES-1:0] event_next
);

  logic [NUM_LINES-1:0] irq_mask, irq_mask_next;
  logic [NUM_LINES-1:0] event_mask, event_mask_next;
  logic [NUM_LINES-1:0] rise_select, rise_select_next;
  logic [NUM_LINES-1:0] fall_select, fall_select_next;
  logic [NUM_LINES-1:0] soft_trigger, soft_trigger_next;
  logic [NUM_LINES-1:0] pending;
  logic [NUM_LINES-1:0] previous_level;
  port_sel_t            port_sel_next;

  logic [NUM_LINES-1:0] wval;
  logic [NUM_LINES-1:0] edges;
  logic [NUM_LINES-1:0] sw_new;
  logic [NUM_LINES-1:0] clr;
  logic [1:0]           grp_sel;

  assign wval    = req.wdata[NUM_LINES-1:0];
  assign grp_sel = 2'(req.addr - REG_PSEL0);

  // Selected edges against the previous sample
  assign edges = (levels & ~previous_level & rise_select) |
                 (~levels & previous_level & fall_select);

  // Register read, old contents
  always_comb begin
    rd_next = '0;
    if (req.func == FUNC_READ) begin
      unique case (req.addr)
        REG_IMASK:   rd_next = DATA_W'(irq_mask);
        REG_EMASK:   rd_next = DATA_W'(event_mask);
        REG_RISE:    rd_next = DATA_W'(rise_select);
        REG_FALL:    rd_next = DATA_W'(fall_select);
        REG_SWTRIG:  rd_next = DATA_W'(soft_trigger);
        REG_PENDING: rd_next = DATA_W'(pending);
        REG_PSEL0, REG_PSEL1, REG_PSEL2, REG_PSEL3: begin
          rd_next = DATA_W'({port_sel[{grp_sel, 2'd3}], port_sel[{grp_sel, 2'd2}],
                             port_sel[{grp_sel, 2'd1}], port_sel[{grp_sel, 2'd0}]});
        end
        default:     rd_next = '0;
      endcase
    end
  end

  // Register write decode
  always_comb begin
    irq_mask_next     = irq_mask;
    event_mask_next   = event_mask;
    rise_select_next  = rise_select;
    fall_select_next  = fall_select;
    soft_trigger_next = soft_trigger;
    port_sel_next     = port_sel;
    sw_new            = '0;
    clr               = '0;
    if (req.func == FUNC_WRITE) begin
      unique case (req.addr)
        REG_IMASK: irq_mask_next    = wval;
        REG_EMASK: event_mask_next  = wval;
        REG_RISE:  rise_select_next = wval;
        REG_FALL:  fall_select_next = wval;
        REG_SWTRIG: begin
          sw_new            = wval & ~soft_trigger;
          soft_trigger_next = soft_trigger | wval;
        end
        REG_PENDING: begin
          clr               = wval;
          soft_trigger_next = soft_trigger & ~wval;
        end
        REG_PSEL0, REG_PSEL1, REG_PSEL2, REG_PSEL3: begin
          for (int k = 0; k < 4; k++) begin
            port_sel_next[{grp_sel, 2'(k)}] = req.wdata[CODE_W*k +: CODE_W];
          end
        end
        default: ;
      endcase
    end
  end

  // Set wins over clear
  assign pending_next = (pending & ~clr) | edges | sw_new;
  assign irq_next     = pending_next & irq_mask_next;
  assign event_next   = (edges | sw_new) & event_mask_next;
  assign grp_next     = {|irq_next[15:10], |irq_next[9:5], irq_next[4:0]};

  // State update, one beat per step
  always_ff @(posedge clk) begin
    if (rst) begin
      irq_mask       <= '0;
      event_mask     <= '0;
      rise_select    <= '0;
      fall_select    <= '0;
      soft_trigger   <= '0;
      pending        <= '0;
      previous_level <= '0;
      port_sel       <= '0;
    end else if (step) begin
      irq_mask       <= irq_mask_next;
      event_mask     <= event_mask_next;
      rise_select    <= rise_select_next;
      fall_select    <= fall_select_next;
      soft_trigger   <= soft_trigger_next;
      pending        <= pending_next;
      previous_level <= levels;
      port_sel       <= port_sel_next;
    end
  end

endmodule

/* hw/rtl/external_interrupt_edge_controller.sv */
// external_interrupt_edge_controller: top level with input and result
// registers around eiec_line_mux and eiec_core. Uses eiec_pkg.
//
//   channel | valid     | stall     | payload
//   --------+-----------+-----------+------------------------------------------
//   input   | in_valid  | in_stall  | func, reg_addr, write_data, pins_*, internal
//   result  | out_valid | out_stall | read_data, pending_bits, irq_lines, ...
//
// One beat per cycle sustained while out_stall is low; a beat taken into the input
// register goes through the single combinational pass of mux and core into the
// result register.
// Synchronous reset clears all control registers and both stage valids.
// A stalled result holds; the input register keeps taking a beat while the
// result register drains, and in_stall rises only when both stages are full.
`timescale 1ns / 1ps

module external_interrupt_edge_controller
  import eiec_pkg::*;
#(
  parameter int NUM_LINES = DEF_NUM_LINES
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                func,
  input  logic [3:0]                reg_addr,
  input  logic [DATA_W-1:0]         write_data,
  input  logic [PIN_FIELD_W-1:0]    pins_low_ports,
  input  logic [PIN_FIELD_W-1:0]    pins_mid_ports,
  input  logic [PIN_FIELD_W-1:0]    pins_high_ports,
  input  logic [INTERNAL_COUNT-1:0] internal_sources,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [DATA_W-1:0]         read_data,
  output logic [NUM_LINES-1:0]      pending_bits,
  output logic [NUM_LINES-1:0]      irq_lines,
  output logic [GROUP_W-1:0]        grouped_irq,
  output logic [NUM_LINES-1:0]      event_pulses
);

  // Input stage
  logic                      s1_valid;
  bus_req_t                  s1_req;
  logic [PIN_FIELD_W-1:0]    s1_pins_low;
  logic [PIN_FIELD_W-1:0]    s1_pins_mid;
  logic [PIN_FIELD_W-1:0]    s1_pins_high;
  logic [INTERNAL_COUNT-1:0] s1_internal;

  logic                      advance;
  logic                      in_take;
  port_sel_t                 port_sel;
  logic [NUM_LINES-1:0]      levels;
  logic [DATA_W-1:0]         rd_next;
  logic [NUM_LINES-1:0]      pending_next;
  logic [NUM_LINES-1:0]      irq_next;
  logic [GROUP_W-1:0]        grp_next;
  logic [NUM_LINES-1:0]      event_next;

  // Handshake: process when the result register is free or draining
  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take || advance) begin
      s1_valid <= in_take;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_req       <= '{func: func, addr: reg_addr, wdata: write_data};
      s1_pins_low  <= pins_low_ports;
      s1_pins_mid  <= pins_mid_ports;
      s1_pins_high <= pins_high_ports;
      s1_internal  <= internal_sources;
    end
  end

  eiec_line_mux #(
    .NUM_LINES(NUM_LINES)
  ) u_mux (
    .port_sel        (port_sel),
    .pins_low_ports  (s1_pins_low),
    .pins_mid_ports  (s1_pins_mid),
    .pins_high_ports (s1_pins_high),
    .internal_sources(s1_internal),
    .levels          (levels)
  );

  eiec_core #(
    .NUM_LINES(NUM_LINES)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .step        (advance),
    .req         (s1_req),
    .levels      (levels),
    .port_sel    (port_sel),
    .rd_next     (rd_next),
    .pending_next(pending_next),
    .irq_next    (irq_next),
    .grp_next    (grp_next),
    .event_next  (event_next)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      read_data    <= rd_next;
      pending_bits <= pending_next;
      irq_lines    <= irq_next;
      grouped_irq  <= grp_next;
      event_pulses <= event_next;
    end
  end

  // Checks
  a_irq_subset: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((irq_lines & ~pending_bits) == '0))
    else $error("irq line set without pending flag");

  a_group_low: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (grouped_irq[4:0] == irq_lines[4:0]))
    else $error("grouped request bits 0-4 differ from irq lines");

  a_read_zero: assert property (@(posedge clk) disable iff (rst)
    (advance && (s1_req.func != FUNC_READ)) |=> (read_data == '0))
    else $error("read data nonzero on a non-read beat");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && out_valid && out_stall))
    else $error("input stalled while a stage is free");

endmodule
